[rtl/sprs_pkg.sv]
// ----------------------------------------------------------------------------
// sprs_pkg
// Shared widths, constants, command/status types for the spherical shell
// relaxation sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sprs_pkg;

	localparam int MAX_LAYERS_DEF = 4096;

	localparam int DATA_W   = 32;
	localparam int ADJ_W    = 18;
	localparam int LAYER_W  = 13;
	localparam int RAD_W    = 35;
	localparam int WGT_W    = 62;
	localparam int DEN_W    = 64;
	localparam int ACC_W    = 96;
	localparam int MOP_W    = 34;
	localparam int PROD_W   = 2 * MOP_W;
	localparam int QUOT_W   = 41;
	localparam int DIVC_W   = 7;
	localparam int SIN_W    = 96;
	localparam int SOUT_W   = 48;
	localparam int CIDX_W   = 3;

	localparam logic [DATA_W-1:0] ONE_Q16    = 32'h0001_0000;
	localparam logic [ADJ_W-1:0]  ADJ_RESET  = 18'h1_0000;
	localparam logic [WGT_W-1:0]  WEIGHT_MAX = {WGT_W{1'b1}};
	localparam logic [QUOT_W-1:0] QUOT_CAP   = {1'b1, {(QUOT_W-1){1'b0}}};

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_OFFSET   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_ADJUST   = 3'd1;
	localparam logic [CIDX_W-1:0] REG_PREFACT  = 3'd2;
	localparam logic [CIDX_W-1:0] REG_LOWER    = 3'd3;
	localparam logic [CIDX_W-1:0] REG_UPPER    = 3'd4;

	// Operations of the shared multiplier.
	typedef enum logic [3:0] {
		MOP_SQ      = 4'd0,
		MOP_PA      = 4'd1,
		MOP_PB      = 4'd2,
		MOP_PFQ_OLD = 4'd3,
		MOP_OW_LO   = 4'd4,
		MOP_OW_HI   = 4'd5,
		MOP_WN_LO   = 4'd6,
		MOP_WN_HI   = 4'd7,
		MOP_PFQ_NEW = 4'd8
	} mop_t;

	// Kind of result being computed.
	typedef enum logic [1:0] {
		RK_LOWER    = 2'd0,
		RK_ONESIDE  = 2'd1,
		RK_INTERIOR = 2'd2,
		RK_EDGE     = 2'd3
	} rkind_t;

	typedef struct packed {
		logic   capture;
		logic   mul;
		logic   wb;
		mop_t   op;
		logic   weight;
		logic   div_init;
		logic   div_step;
		logic   round;
		logic   emit;
		rkind_t kind;
		logic   res_last;
		logic   update;
	} cmd_t;

	typedef struct packed {
		logic first;
		logic n_two;
		logic n_three;
		logic zero_off;
		logic lower;
		logic upper;
		logic last;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

[rtl/sprs_ctrl.sv]
// ----------------------------------------------------------------------------
// sprs_ctrl
// Sequencer: steps the shared multiplier, the divider and the result
// hand-off for each layer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sprs_ctrl
	import sprs_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output logic       s_tready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_MUL      = 9'b000000010,
		ST_WB       = 9'b000000100,
		ST_WEIGHT   = 9'b000001000,
		ST_DIV_INIT = 9'b000010000,
		ST_DIV      = 9'b000100000,
		ST_ROUND    = 9'b001000000,
		ST_EMIT     = 9'b010000000,
		ST_UPDATE   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	mop_t   op_q, op_d;
	rkind_t kind_q, kind_d;
	logic   pend_q, pend_d;

	logic   edge_go;
	logic   have_first;
	rkind_t first_kind;

	assign s_tready = (state_q == ST_IDLE);

	// Which results this layer produces.
	always_comb begin
		edge_go = stat.last && stat.upper && !(stat.zero_off && stat.n_two);
		priority if (stat.n_two) begin
			have_first = !stat.zero_off && stat.lower;
			first_kind = RK_LOWER;
		end else if (stat.zero_off && stat.n_three) begin
			have_first = 1'b1;
			first_kind = RK_ONESIDE;
		end else begin
			have_first = 1'b1;
			first_kind = RK_INTERIOR;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		kind_d  = kind_q;
		pend_d  = pend_q;
		cmd     = '0;
		cmd.op   = op_q;
		cmd.kind = kind_q;
		cmd.res_last = (kind_q == RK_EDGE) || (stat.last && !pend_q);
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					op_d = MOP_SQ;
					state_d = stat.first ? ST_UPDATE : ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_WB;
			end
			ST_WB: begin
				cmd.wb = 1'b1;
				state_d = ST_MUL;
				unique case (op_q)
					MOP_SQ:      op_d = MOP_PA;
					MOP_PA:      op_d = MOP_PB;
					MOP_PB:      state_d = ST_WEIGHT;
					MOP_PFQ_OLD: begin
						if (kind_q == RK_INTERIOR) begin
							op_d = MOP_OW_LO;
						end else begin
							state_d = ST_DIV_INIT;
						end
					end
					MOP_OW_LO:   op_d = MOP_OW_HI;
					MOP_OW_HI:   op_d = MOP_WN_LO;
					MOP_WN_LO:   op_d = MOP_WN_HI;
					MOP_WN_HI:   state_d = ST_DIV_INIT;
					MOP_PFQ_NEW: state_d = ST_DIV_INIT;
					default:     state_d = ST_DIV_INIT;
				endcase
			end
			ST_WEIGHT: begin
				cmd.weight = 1'b1;
				pend_d = edge_go;
				if (have_first) begin
					kind_d = first_kind;
					op_d = MOP_PFQ_OLD;
					state_d = ST_MUL;
				end else if (edge_go) begin
					kind_d = RK_EDGE;
					op_d = MOP_PFQ_NEW;
					state_d = ST_MUL;
				end else begin
					state_d = ST_UPDATE;
				end
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (kind_q != RK_EDGE && pend_q) begin
						kind_d = RK_EDGE;
						op_d = MOP_PFQ_NEW;
						state_d = ST_MUL;
					end else begin
						state_d = ST_UPDATE;
					end
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= MOP_SQ;
			kind_q  <= RK_INTERIOR;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			kind_q  <= kind_d;
			pend_q  <= pend_d;
		end
	end

endmodule

`default_nettype wire

[rtl/sprs_datapath.sv]
// ----------------------------------------------------------------------------
// sprs_datapath
// Registers, shared multiplier, restoring divider and output register of
// the shell relaxation sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sprs_datapath
	import sprs_pkg::*;
#(
	parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CIDX_W-1:0]   cfg_index,
	input  wire logic [DATA_W-1:0]   cfg_data,
	input  wire logic [SIN_W-1:0]    s_tdata,
	input  wire logic                s_tlast,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [SOUT_W-1:0]        m_tdata,
	output logic                     m_tlast,
	input  wire cmd_t                cmd,
	output stat_t                    stat
);

	localparam int CW  = $clog2(MAX_LAYERS + 1);
	localparam int LNW = (CW > LAYER_W) ? CW : LAYER_W;

	// Configuration.
	logic [DATA_W-1:0] off_q, pf_q;
	logic [ADJ_W-1:0]  adj_q;
	logic              lower_q, upper_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			adj_q   <= ADJ_RESET;
			pf_q    <= ONE_Q16;
			lower_q <= 1'b0;
			upper_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFFSET:  off_q   <= cfg_data;
				REG_ADJUST:  adj_q   <= cfg_data[ADJ_W-1:0];
				REG_PREFACT: pf_q    <= cfg_data;
				REG_LOWER:   lower_q <= cfg_data[0];
				REG_UPPER:   upper_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sweep state and captured layer.
	logic [CW-1:0]     cnt_q, n_q, n_c;
	logic [RAD_W-1:0]  rad_q;
	logic [WGT_W-1:0]  ow_q, wn_q;
	logic [DATA_W-1:0] held_e_q, held_c_q, one_q, two_q;
	logic [DATA_W-1:0] pin_q, ein_q, qin_q;
	logic              last_q, last_c;

	assign n_c    = cnt_q + CW'(1);
	assign last_c = s_tlast || (n_c >= CW'(MAX_LAYERS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.update) begin
			cnt_q <= last_q ? '0 : n_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pin_q  <= s_tdata[31:0];
			ein_q  <= s_tdata[63:32];
			qin_q  <= s_tdata[95:64];
			last_q <= last_c;
			n_q    <= n_c;
			if (cnt_q == '0) begin
				rad_q <= {3'b000, off_q} + {{(RAD_W-ADJ_W){1'b0}}, adj_q}
					- {3'b000, ONE_Q16};
			end else if (n_c > CW'(2)) begin
				rad_q <= rad_q + {3'b000, ONE_Q16};
			end
		end
		if (cmd.update) begin
			ow_q     <= (n_q == CW'(1)) ? '0 : wn_q;
			two_q    <= (n_q == CW'(1)) ? '0 : one_q;
			one_q    <= pin_q;
			held_e_q <= ein_q;
			held_c_q <= qin_q;
		end
	end

	// Radius magnitude, saturated to 32 bits.
	logic [RAD_W-1:0]  rad_abs;
	logic [DATA_W-1:0] mag;
	logic [DATA_W:0]   eps_sum;

	assign rad_abs = rad_q[RAD_W-1] ? (~rad_q + RAD_W'(1)) : rad_q;
	assign mag     = (rad_abs[RAD_W-1:DATA_W] != '0) ? {DATA_W{1'b1}} : rad_abs[DATA_W-1:0];
	assign eps_sum = {1'b0, held_e_q} + {1'b0, ein_q};

	// Shared multiplier.
	logic [63:0]              sq_q;
	logic [64:0]              pa_q, pb_q;
	logic signed [MOP_W-1:0]  ma, mb;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;

	always_comb begin
		unique case (cmd.op)
			MOP_SQ: begin
				ma = {2'b00, mag};
				mb = {2'b00, mag};
			end
			MOP_PA: begin
				ma = {2'b00, sq_q[31:0]};
				mb = {1'b0, eps_sum};
			end
			MOP_PB: begin
				ma = {2'b00, sq_q[63:32]};
				mb = {1'b0, eps_sum};
			end
			MOP_PFQ_OLD: begin
				ma = {{2{pf_q[31]}}, pf_q};
				mb = {{2{held_c_q[31]}}, held_c_q};
			end
			MOP_OW_LO: begin
				ma = {{2{two_q[31]}}, two_q};
				mb = {2'b00, ow_q[31:0]};
			end
			MOP_OW_HI: begin
				ma = {{2{two_q[31]}}, two_q};
				mb = {4'b0000, ow_q[61:32]};
			end
			MOP_WN_LO: begin
				ma = {{2{pin_q[31]}}, pin_q};
				mb = {2'b00, wn_q[31:0]};
			end
			MOP_WN_HI: begin
				ma = {{2{pin_q[31]}}, pin_q};
				mb = {4'b0000, wn_q[61:32]};
			end
			MOP_PFQ_NEW: begin
				ma = {{2{pf_q[31]}}, pf_q};
				mb = {{2{qin_q[31]}}, qin_q};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	logic [96:0] wfull;
	assign wfull = {pb_q, 32'h0} + {32'h0, pa_q};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= ma * mb;
		end
		if (cmd.wb) begin
			unique case (cmd.op)
				MOP_SQ:      sq_q <= prod_q[63:0];
				MOP_PA:      pa_q <= prod_q[64:0];
				MOP_PB:      pb_q <= prod_q[64:0];
				MOP_PFQ_OLD,
				MOP_PFQ_NEW: acc_q <= {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
				MOP_OW_LO,
				MOP_WN_LO:   acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
				MOP_OW_HI,
				MOP_WN_HI:   acc_q <= acc_q + {prod_q[63:0], 32'h0};
				default: ;
			endcase
		end
		// The face weight is floor(R^2 * eps_sum / 2^32), saturated.
		if (cmd.weight) begin
			wn_q <= (wfull[96:94] != '0) ? WEIGHT_MAX : wfull[93:32];
		end
	end

	// Restoring divider, one quotient bit per cycle; only the low 41 bits
	// of the quotient are kept, anything above marks it as too big.
	logic [ACC_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q, rem_q;
	logic [QUOT_W-1:0] quo_q, qmag_q;
	logic [DIVC_W-1:0] dcnt_q;
	logic              neg_q, big_q;
	logic [DEN_W:0]    rtry;
	logic              rge;
	logic [QUOT_W:0]   qrnd;

	assign rtry = {rem_q, num_q[ACC_W-1]};
	assign rge  = (rtry >= {1'b0, den_q});
	assign qrnd = {1'b0, quo_q} + {{QUOT_W{1'b0}}, (rem_q >= (den_q - rem_q))};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			neg_q  <= acc_q[ACC_W-1];
			num_q  <= acc_q[ACC_W-1] ? (~acc_q + ACC_W'(1)) : acc_q;
			den_q  <= (cmd.kind == RK_INTERIOR) ? ({2'b00, ow_q} + {2'b00, wn_q})
				: {2'b00, wn_q};
			rem_q  <= '0;
			quo_q  <= '0;
			big_q  <= 1'b0;
			dcnt_q <= DIVC_W'(ACC_W - 1);
		end
		if (cmd.div_step) begin
			num_q  <= {num_q[ACC_W-2:0], 1'b0};
			rem_q  <= rge ? (rtry[DEN_W-1:0] - den_q) : rtry[DEN_W-1:0];
			quo_q  <= {quo_q[QUOT_W-2:0], rge};
			big_q  <= big_q | quo_q[QUOT_W-1];
			dcnt_q <= dcnt_q - DIVC_W'(1);
		end
		if (cmd.round) begin
			priority if (den_q == '0) begin
				qmag_q <= '0;
			end else if (big_q || quo_q > QUOT_CAP) begin
				qmag_q <= QUOT_CAP;
			end else if (qrnd > {1'b0, QUOT_CAP}) begin
				qmag_q <= QUOT_CAP;
			end else begin
				qmag_q <= qrnd[QUOT_W-1:0];
			end
		end
	end

	// Result: sign, neighbour potential for the boundary rules, saturation.
	logic signed [QUOT_W+1:0] qsig, nbr, vsum;
	logic [DATA_W-1:0]        nbr_raw, res;
	logic [LNW-1:0]           layer_w;

	always_comb begin
		qsig    = neg_q ? -$signed({2'b00, qmag_q}) : $signed({2'b00, qmag_q});
		nbr_raw = (cmd.kind == RK_EDGE) ? one_q : pin_q;
		nbr     = {{(QUOT_W+2-DATA_W){nbr_raw[DATA_W-1]}}, nbr_raw};
		vsum    = (cmd.kind == RK_INTERIOR) ? qsig : (qsig + nbr);
		priority if (!vsum[QUOT_W+1] && vsum[QUOT_W:DATA_W-1] != '0) begin
			res = 32'h7FFF_FFFF;
		end else if (vsum[QUOT_W+1] && vsum[QUOT_W:DATA_W-1] != '1) begin
			res = 32'h8000_0000;
		end else begin
			res = vsum[DATA_W-1:0];
		end
		layer_w = (cmd.kind == RK_EDGE) ? LNW'(n_q) : LNW'(n_q - CW'(1));
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata <= {3'b000, res, layer_w[LAYER_W-1:0]};
			m_tlast <= cmd.res_last;
		end
	end

	always_comb begin
		stat.first    = (cnt_q == '0);
		stat.n_two    = (n_q == CW'(2));
		stat.n_three  = (n_q == CW'(3));
		stat.zero_off = (off_q == '0);
		stat.lower    = lower_q;
		stat.upper    = upper_q;
		stat.last     = last_q;
		stat.div_last = (dcnt_q == '0);
		stat.out_free = !m_tvalid || m_tready;
	end

endmodule

`default_nettype wire

[rtl/spherical_potential_relaxation_sweep.sv]
// ----------------------------------------------------------------------------
// spherical_potential_relaxation_sweep
// Jacobi relaxation sweep over spherical shells, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Layers stream in one transfer each; the result for layer z leaves when
// layer z+1 has been taken, and the last layer may add a second result.
// Layer 1 of a sweep is only captured and stored. Every later layer runs
// through one shared 34x34 multiplier (the weight, then the numerator) and
// a 96-step restoring divider, one quotient bit per cycle. A layer that
// gives no result stops after the weight; a result, the interior one or
// one by a boundary rule, or the edge result of a last layer, waits for
// the output register to free up before it leaves. One layer is in
// work at a time; the next is taken while a finished result still waits
// at the output.
`timescale 1ns / 1ps
`default_nettype none

module spherical_potential_relaxation_sweep
	import sprs_pkg::*;
#(
	parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CIDX_W-1:0]  cfg_index,
	input  wire logic [DATA_W-1:0]  cfg_data,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	// [31:0] old_potential, [63:32] permittivity, [95:64] layer_charge
	input  wire logic [SIN_W-1:0]   s_tdata,
	input  wire logic               s_tlast,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// [12:0] layer_number, [44:13] new_potential, [47:45] zero
	output logic [SOUT_W-1:0]       m_tdata,
	output logic                    m_tlast
);

	cmd_t  cmd;
	stat_t stat;

	sprs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sprs_datapath #(
		.MAX_LAYERS (MAX_LAYERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire
